FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked assertion on the usual clk_i and rst_ni
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/pnat_pkg.sv
// types and constants of the point and normal affine transform
package pnat_pkg;

  localparam int POS_W       = 32;
  localparam int NRM_W       = 16;
  localparam int COEF_W      = 16;
  localparam int ROW_W       = 3 * COEF_W;
  localparam int ROUND_SHIFT = 14;
  localparam int ROUND_HALF  = 8192;
  localparam int PPROD_W     = POS_W + COEF_W;        // 16 x 32 product
  localparam int NPROD_W     = NRM_W + COEF_W;        // 16 x 16 product
  localparam int PSUM_W      = PPROD_W + 2;           // three products plus half
  localparam int NSUM_W      = NPROD_W + 2;
  localparam int PTR_W       = PSUM_W - ROUND_SHIFT + 1; // rounded plus translation
  localparam int NTR_W       = NSUM_W - ROUND_SHIFT;
  localparam int CFG_IDX_W   = 3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3,
    REG_TRANS_Y  = 3'd4,
    REG_TRANS_Z  = 3'd5
  } pnat_reg_e;

  // rotation matrix, [row][column], column 0 in the low bits of a row
  typedef logic [2:0][2:0][COEF_W-1:0] pnat_rot_t;
  typedef logic [2:0][POS_W-1:0]       pnat_trans_t;

  localparam logic [COEF_W-1:0] ONE_Q14  = 16'h4000;
  localparam logic [COEF_W-1:0] ZERO_Q14 = 16'h0000;

  localparam pnat_rot_t ROT_RESET = '{
    '{ONE_Q14,  ZERO_Q14, ZERO_Q14},
    '{ZERO_Q14, ONE_Q14,  ZERO_Q14},
    '{ZERO_Q14, ZERO_Q14, ONE_Q14}
  };

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } pnat_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] out_pos_x;
    logic signed [POS_W-1:0] out_pos_y;
    logic signed [POS_W-1:0] out_pos_z;
    logic signed [NRM_W-1:0] out_nrm_x;
    logic signed [NRM_W-1:0] out_nrm_y;
    logic signed [NRM_W-1:0] out_nrm_z;
  } pnat_out_t;

  // products, [row][column]
  typedef struct packed {
    logic [2:0][2:0][PPROD_W-1:0] pos;
    logic [2:0][2:0][NPROD_W-1:0] nrm;
  } pnat_prod_t;

  // row sums with the rounding half already added
  typedef struct packed {
    logic [2:0][PSUM_W-1:0] pos;
    logic [2:0][NSUM_W-1:0] nrm;
  } pnat_sum_t;

endpackage

FILE: rtl/pnat_mul.sv
// first stage: the eighteen coefficient products
module pnat_mul import pnat_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  pnat_rot_t  rot_i,
  input  pnat_in_t   item_i,
  output pnat_prod_t prod_o
);

  logic [2:0][POS_W-1:0] pos_v;
  logic [2:0][NRM_W-1:0] nrm_v;
  pnat_prod_t            prod_d, prod_q;

  // vector view of the item
  always_comb begin
    pos_v[0] = item_i.pos_x;
    pos_v[1] = item_i.pos_y;
    pos_v[2] = item_i.pos_z;
    nrm_v[0] = item_i.nrm_x;
    nrm_v[1] = item_i.nrm_y;
    nrm_v[2] = item_i.nrm_z;
  end

  // signed products per row and column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d.pos[r][c] = PPROD_W'($signed(rot_i[r][c])) * PPROD_W'($signed(pos_v[c]));
        prod_d.nrm[r][c] = NPROD_W'($signed(rot_i[r][c])) * NPROD_W'($signed(nrm_v[c]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/pnat_sum.sv
// second stage: row sums plus the rounding half
module pnat_sum import pnat_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  pnat_prod_t prod_i,
  output pnat_sum_t  sum_o
);

  pnat_sum_t sum_d, sum_q;

  // three products and half an lsb of the result
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d.pos[r] = PSUM_W'($signed(prod_i.pos[r][0])) + PSUM_W'($signed(prod_i.pos[r][1]))
                   + PSUM_W'($signed(prod_i.pos[r][2])) + PSUM_W'(ROUND_HALF);
      sum_d.nrm[r] = NSUM_W'($signed(prod_i.nrm[r][0])) + NSUM_W'($signed(prod_i.nrm[r][1]))
                   + NSUM_W'($signed(prod_i.nrm[r][2])) + NSUM_W'(ROUND_HALF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/pnat_sat.sv
// third stage: floor shift, translation and saturation
module pnat_sat import pnat_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  pnat_trans_t trans_i,
  input  pnat_sum_t   sum_i,
  output pnat_out_t   item_o
);

  logic [2:0][PTR_W-1:0] pos_t;
  logic [2:0][NTR_W-1:0] nrm_t;
  logic [2:0][POS_W-1:0] pos_s;
  logic [2:0][NRM_W-1:0] nrm_s;
  pnat_out_t             item_d, item_q;

  // drop the fraction bits, add translation to positions
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pos_t[r] = PTR_W'($signed(sum_i.pos[r][PSUM_W-1:ROUND_SHIFT]))
               + PTR_W'($signed(trans_i[r]));
      nrm_t[r] = sum_i.nrm[r][NSUM_W-1:ROUND_SHIFT];
    end
  end

  // clamp when the bits above the field do not all match its sign
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if ((&pos_t[r][PTR_W-1:POS_W-1]) || !(|pos_t[r][PTR_W-1:POS_W-1])) begin
        pos_s[r] = pos_t[r][POS_W-1:0];
      end else begin
        pos_s[r] = pos_t[r][PTR_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      if ((&nrm_t[r][NTR_W-1:NRM_W-1]) || !(|nrm_t[r][NTR_W-1:NRM_W-1])) begin
        nrm_s[r] = nrm_t[r][NRM_W-1:0];
      end else begin
        nrm_s[r] = nrm_t[r][NTR_W-1] ? {1'b1, {(NRM_W-1){1'b0}}} : {1'b0, {(NRM_W-1){1'b1}}};
      end
    end
  end

  always_comb begin
    item_d.out_pos_x = pos_s[0];
    item_d.out_pos_y = pos_s[1];
    item_d.out_pos_z = pos_s[2];
    item_d.out_nrm_x = nrm_s[0];
    item_d.out_nrm_y = nrm_s[1];
    item_d.out_nrm_z = nrm_s[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

FILE: rtl/point_normal_affine_transform.sv
// top level of the point and normal affine transform
//
// Each input item carries a Q16.16 position and a Q2.14 normal. The result
// item holds R*pos + T (Q16.16) and R*nrm (Q2.14), each rounded to nearest
// with ties upward and saturated to its field width.
// Both channels use valid and stall: an item moves at a rising edge where
// valid is high and stall is low.
// R and T are set through the write port (cfg_we_i, cfg_idx_i, cfg_data_i):
// indexes 0..2 are the rotation rows, 3..5 the translation, others are
// ignored. Write only while no item is in flight.
// There are three register stages (products, row sums, then shift, translate
// and saturate); an accepted item passes through them in that order and
// out_valid_o shows that the last stage holds a result.
// One item is taken every cycle while the receiver does not stall, as each
// stage passes its item on while it takes the next.
// When the receiver stalls, the result holds and the stages behind it fill
// up; in_stall_o rises only once all three stages hold an item.
// Reset empties the pipeline and loads R as identity and T as zero.
module point_normal_affine_transform import pnat_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ROW_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pnat_in_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pnat_out_t             out_item_o
);

  `include "assert_macros.svh"

  pnat_rot_t   rot_q;
  pnat_trans_t trans_q;
  pnat_prod_t  prod;
  pnat_sum_t   sum;
  logic        v1_q, v2_q, v3_q;
  logic        rdy1, rdy2, rdy3;
  logic        en1, en2, en3;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= ROT_RESET;
      trans_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROT_ROW0: rot_q[0]   <= cfg_data_i;
        REG_ROT_ROW1: rot_q[1]   <= cfg_data_i;
        REG_ROT_ROW2: rot_q[2]   <= cfg_data_i;
        REG_TRANS_X:  trans_q[0] <= cfg_data_i[POS_W-1:0];
        REG_TRANS_Y:  trans_q[1] <= cfg_data_i[POS_W-1:0];
        REG_TRANS_Z:  trans_q[2] <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage takes an item when it is empty or its item moves on
  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign en1  = in_valid_i && rdy1;
  assign en2  = v1_q && rdy2;
  assign en3  = v2_q && rdy3;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v3_q;

  pnat_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (en1),
    .rot_i  (rot_q),
    .item_i (in_item_i),
    .prod_o (prod)
  );

  pnat_sum u_sum (
    .clk_i  (clk_i),
    .en_i   (en2),
    .prod_i (prod),
    .sum_o  (sum)
  );

  pnat_sat u_sat (
    .clk_i   (clk_i),
    .en_i    (en3),
    .trans_i (trans_q),
    .sum_i   (sum),
    .item_o  (out_item_o)
  );

  // pipeline checks
  `ASSERT_STD(a_accept_fills, (in_valid_i && !in_stall_o) |=> v1_q, "item not in stage one")
  `ASSERT_STD(a_stall_full, in_stall_o |-> (v1_q && v2_q && v3_q && out_stall_i), "needless stall")
  `ASSERT_STD(a_hold_stage2, (v2_q && v3_q && out_stall_i) |=> v2_q, "stage two lost")
  `ASSERT_STD(a_advance, (v1_q && !v2_q) |=> v2_q, "stage one item did not advance")

endmodule
